### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// stream widths and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic put;
    logic read;
    logic clear_start;
    logic scroll_start;
    logic sweep_run;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       wrap;
    logic       sweep_done;
  } sts_t;

endpackage

### rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: COLUMNS x ROWS store of character/attribute cells with
// a write cursor, newline handling, scroll on overflow, clear and cell read.
//
//   channel  direction  handshake                     payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   s_axis_tuser[1:0], s_axis_tdata[23:0]
//   m_axis   out        m_axis_tvalid/m_axis_tready   m_axis_tdata[31:0]
//   cfg      in         cfg_valid/cfg_ready           cfg_data[7:0]
//
// Put, read and no-op: a request goes from accept through address setup
// and its action to the result register. Clear and scrolling put add a
// sweep of the store, one cell per cycle, through the single write port and
// single read port of the cell store. After reset a clearing pass zeroes
// the store; no request is taken until it ends.
// A result waiting on m_axis does not block the next request from being
// taken; only its completion waits for the output register.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // command[1:0]
  input  logic [1:0]                s_axis_tuser,
  // char_code[7:0], use_position[8], column[15:9], line[20:16]
  input  logic [tcw_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // cursor_column[6:0], cursor_line[11:7], scrolled[12], cell_char[20:13],
  // cell_attr[28:21]
  output logic [tcw_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data
);
  import tcw_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .in_cmd   (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (m_axis_tdata)
  );

endmodule

### rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: takes a request, steps the datapath through
// address setup, the command's action and any store sweep, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::ctl_t ctl
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_ACT   = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_INIT: begin
        ctl.sweep_run = 1'b1;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_ACT;
      end
      S_ACT: begin
        state_next = S_DONE;
        case (sts.cmd)
          CMD_PUT: begin
            ctl.put = 1'b1;
            if (sts.wrap) begin
              ctl.scroll_start = 1'b1;
              state_next       = S_SWEEP;
            end
          end
          CMD_CLEAR: begin
            ctl.clear_start = 1'b1;
            state_next      = S_SWEEP;
          end
          CMD_READ: ctl.read = 1'b1;
          default: ;
        endcase
      end
      S_SWEEP: begin
        ctl.sweep_run = 1'b1;
        if (sts.sweep_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### rtl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath of the console: cell store, cursor, attribute register, store
// sweep counter for clear and scroll, and the result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::ctl_t              ctl,
  output tcw_pkg::sts_t              sts,
  input  logic [1:0]                 in_cmd,
  input  logic [tcw_pkg::IN_W-1:0]   in_data,
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_data,
  output logic [tcw_pkg::OUT_W-1:0]  out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  logic [7:0]    attr;
  logic [1:0]    cmd;
  logic [7:0]    char_code;
  logic          use_pos;
  logic [CW-1:0] in_col, cur_col, eff_col;
  logic [RW-1:0] in_row, cur_row, eff_row;
  logic [AW-1:0] addr;
  logic          scrolled;

  logic [KW-1:0] k;
  logic          scroll_mode;
  logic [15:0]   fill_word;

  logic          is_newline, col_last, row_last, adv_row;
  logic [6:0]    col_field;
  logic [4:0]    row_field;

  assign col_field = in_data[15:9];
  assign row_field = in_data[20:16];

  assign is_newline = (char_code == NEWLINE_CODE);
  assign col_last   = (cur_col == CW'(COLUMNS - 1));
  assign row_last   = (cur_row == RW'(ROWS - 1));
  assign adv_row    = is_newline || col_last;

  assign sts.cmd        = cmd;
  assign sts.wrap       = adv_row && row_last;
  assign sts.sweep_done = (k == KW'(CELLS));

  assign eff_col = ((cmd != CMD_PUT) || use_pos) ? in_col : cur_col;
  assign eff_row = ((cmd != CMD_PUT) || use_pos) ? in_row : cur_row;

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {attr, char_code};
    re    = 1'b0;
    raddr = addr;
    if (ctl.put && !is_newline) begin
      we = 1'b1;
    end else if (ctl.sweep_run) begin
      we    = (k != '0);
      waddr = AW'(k - KW'(1));
      if (!scroll_mode) wdata = fill_word;
      else if (k <= KW'(CELLS - COLUMNS)) wdata = rd_data;
      else wdata = '0;
    end
    if (ctl.read) begin
      re = 1'b1;
    end else if (ctl.sweep_run && scroll_mode) begin
      re    = (k < KW'(CELLS - COLUMNS));
      raddr = AW'({1'b0, k} + (KW + 1)'(COLUMNS));
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr        <= ATTR_RESET;
      cur_col     <= '0;
      cur_row     <= '0;
      k           <= '0;
      scroll_mode <= 1'b0;
      fill_word   <= '0;
    end else begin
      if (cfg_we) attr <= cfg_data;
      if (ctl.exec && (cmd == CMD_PUT) && use_pos) begin
        cur_col <= in_col;
        cur_row <= in_row;
      end
      if (ctl.put) begin
        if (adv_row) begin
          cur_col <= '0;
          if (!row_last) cur_row <= cur_row + RW'(1);
        end else begin
          cur_col <= cur_col + CW'(1);
        end
      end
      if (ctl.clear_start) begin
        cur_col     <= '0;
        cur_row     <= '0;
        scroll_mode <= 1'b0;
        fill_word   <= {attr, SPACE_CODE};
      end
      if (ctl.scroll_start) scroll_mode <= 1'b1;
      if (ctl.sweep_run) k <= sts.sweep_done ? '0 : k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd       <= in_cmd;
      char_code <= in_data[7:0];
      use_pos   <= in_data[8];
      in_col    <= (int'(col_field) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(col_field);
      in_row    <= (int'(row_field) >= ROWS) ? RW'(ROWS - 1) : RW'(row_field);
      scrolled  <= 1'b0;
    end
    if (ctl.scroll_start) scrolled <= 1'b1;
    if (ctl.exec) addr <= AW'(int'(eff_row) * COLUMNS + int'(eff_col));
    if (ctl.load_out) begin
      out_data[6:0]   <= 7'(cur_col);
      out_data[11:7]  <= 5'(cur_row);
      out_data[12]    <= scrolled;
      out_data[28:13] <= (cmd == CMD_READ) ? rd_data : 16'd0;
      out_data[31:29] <= '0;
    end
  end

endmodule
